/* design/rfvt_pkg.sv */
package rfvt_pkg;

    typedef enum logic [1:0] {
        ACT_ROT  = 2'd0,
        ACT_KEP  = 2'd1,
        ACT_PASS = 2'd2,
        ACT_BAD  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ACTION = 2'd1,
        ST_ZERO_RAD   = 2'd2,
        ST_SAT        = 2'd3
    } status_t;

    // what the back end has to do with a request
    typedef enum logic [2:0] {
        K_ROT,
        K_KEP,
        K_PASS,
        K_BAD,
        K_ZERO
    } kind_t;

    // p0/p1: vx-y / vy+x, |y| / |x|, or vx / vy depending on kind
    typedef struct packed {
        kind_t              kind;
        logic signed [32:0] p0;
        logic signed [32:0] p1;
        logic               sx;
        logic               sy;
        logic [23:0]        q;
    } rfvt_item_t;

    localparam logic [23:0] MASS_RATIO_RESET = 24'd65536;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // msb flags clamping
    function automatic logic [32:0] sat32(input logic signed [35:0] v);
        logic [32:0] r;
        if (v > 36'sd2147483647) begin
            r = {1'b1, S32_MAX};
        end else if (v < -36'sd2147483648) begin
            r = {1'b1, S32_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

/* design/rfvt_sqrt_pipe.sv */
module rfvt_sqrt_pipe #(
    parameter int RW = 64,
    parameter int TW = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [RW-1:0]     rad_i,
    input  logic [TW-1:0]     tag_i,
    output logic [RW/2-1:0]   root_o,
    output logic [TW-1:0]     tag_o
);
    localparam int HW = RW / 2;
    localparam int TRW = HW + 3;
    localparam int RMW = HW + 1;

    logic [HW:0]    rem_s  [HW+1];
    logic [HW-1:0]  root_s [HW+1];
    logic [RW-1:0]  rad_s  [HW+1];
    logic [TW-1:0]  tag_s  [HW+1];

    logic [HW:0]    rem_reg  [HW];
    logic [HW-1:0]  root_reg [HW];
    logic [RW-1:0]  rad_reg  [HW];
    logic [TW-1:0]  tag_reg  [HW];

    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign rad_s[0]  = rad_i;
    assign tag_s[0]  = tag_i;

    // one result bit per stage, two radicand bits shifted in
    for (genvar i = 0; i < HW; i++) begin : g_stage
        logic [HW+2:0] t;
        logic [HW+2:0] trial;
        logic          ge;

        assign t     = {rem_s[i], rad_s[i][RW-1 -: 2]};
        assign trial = TRW'({root_s[i], 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? RMW'(t - trial) : t[HW:0];
                root_reg[i] <= {root_s[i][HW-2:0], ge};
                rad_reg[i]  <= {rad_s[i][RW-3:0], 2'b00};
                tag_reg[i]  <= tag_s[i];
            end
        end

        assign rem_s[i+1]  = rem_reg[i];
        assign root_s[i+1] = root_reg[i];
        assign rad_s[i+1]  = rad_reg[i];
        assign tag_s[i+1]  = tag_reg[i];
    end

    assign root_o = root_s[HW];
    assign tag_o  = tag_s[HW];

endmodule

/* design/rfvt_div_pipe.sv */
module rfvt_div_pipe #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int TW = 8
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [NW-1:0]  num_i,
    input  logic [DW-1:0]  den_i,
    input  logic [TW-1:0]  tag_i,
    output logic [NW-1:0]  quo_o,
    output logic [TW-1:0]  tag_o
);
    localparam int TDW = DW + 1;

    logic [DW-1:0] rem_s [NW+1];
    logic [NW-1:0] num_s [NW+1];
    logic [DW-1:0] den_s [NW+1];
    logic [TW-1:0] tag_s [NW+1];

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [TW-1:0] tag_reg [NW];

    assign rem_s[0] = '0;
    assign num_s[0] = num_i;
    assign den_s[0] = den_i;
    assign tag_s[0] = tag_i;

    // restoring division, quotient bits shift in behind the dividend
    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW:0] t;
        logic        ge;

        assign t  = {rem_s[i], num_s[i][NW-1]};
        assign ge = (t >= TDW'(den_s[i]));

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? DW'(t - TDW'(den_s[i])) : t[DW-1:0];
                num_reg[i] <= {num_s[i][NW-2:0], ge};
                den_reg[i] <= den_s[i];
                tag_reg[i] <= tag_s[i];
            end
        end

        assign rem_s[i+1] = rem_reg[i];
        assign num_s[i+1] = num_reg[i];
        assign den_s[i+1] = den_reg[i];
        assign tag_s[i+1] = tag_reg[i];
    end

    assign quo_o = num_s[NW];
    assign tag_o = tag_s[NW];

endmodule

/* design/rfvt_front.sv */
module rfvt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [23:0]          cfg_data,
    output logic                 item_valid,
    output rfvt_pkg::rfvt_item_t item,
    input  logic                 item_ready
);
    import rfvt_pkg::*;

    logic [23:0]        mass_ratio_reg;
    logic signed [32:0] x33, y33, vx33, vy33, ax33, ay33;
    rfvt_item_t         cls;
    rfvt_item_t         qmem_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_ratio_reg <= MASS_RATIO_RESET;
        end else if (cfg_valid) begin
            mass_ratio_reg <= cfg_data;
        end
    end

    assign x33  = {s_tdata[31], s_tdata[31:0]};
    assign y33  = {s_tdata[63], s_tdata[63:32]};
    assign vx33 = {s_tdata[95], s_tdata[95:64]};
    assign vy33 = {s_tdata[127], s_tdata[127:96]};
    assign ax33 = x33[32] ? -x33 : x33;
    assign ay33 = y33[32] ? -y33 : y33;

    always_comb begin
        cls.kind = K_BAD;
        cls.p0   = '0;
        cls.p1   = '0;
        cls.sx   = x33[32];
        cls.sy   = y33[32];
        cls.q    = mass_ratio_reg;
        unique case (action_t'(s_tuser))
            ACT_ROT: begin
                cls.kind = K_ROT;
                cls.p0   = vx33 - y33;
                cls.p1   = vy33 + x33;
            end
            ACT_KEP: begin
                cls.kind = (x33 == '0 && y33 == '0) ? K_ZERO : K_KEP;
                cls.p0   = ay33;
                cls.p1   = ax33;
            end
            ACT_PASS: begin
                cls.kind = K_PASS;
                cls.p0   = vx33;
                cls.p1   = vy33;
            end
            default: begin
                cls.kind = K_BAD;
            end
        endcase
    end

    // two-entry queue toward the back end
    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_valid && item_ready;
    assign item       = qmem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            qmem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_comb begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/rfvt_back.sv */
module rfvt_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  rfvt_pkg::rfvt_item_t item,
    output logic                 item_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    import rfvt_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int IW   = $bits(rfvt_item_t);
    localparam int QW   = ((F > 24) ? F : 24) + 1;
    localparam int PW   = QW + 32;
    localparam int RW2  = PW + (PW % 2);
    localparam int DW2  = RW2 / 2;
    localparam int NWD  = 32 + F;
    localparam int NWV  = 2 * F + 1;
    localparam int PLW  = 33 + F;
    localparam int PRW  = 65 + F;
    localparam int T2W  = 3 * F + 2 + IW;
    localparam int T3W  = F + IW;
    localparam int LAT  = 2 + 32 + NWD + 1 + DW2 + NWV + 2;

    logic            en;
    logic [LAT-1:0]  vld_reg;

    assign en         = !m_tvalid || m_tready;
    assign item_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], item_valid};
        end
    end

    // squares, then their sum
    logic [63:0] sqa_reg, sqb_reg, sum_reg;
    rfvt_item_t  ita_reg, itb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa_reg <= 64'(item.p0[31:0]) * 64'(item.p0[31:0]);
            sqb_reg <= 64'(item.p1[31:0]) * 64'(item.p1[31:0]);
            ita_reg <= item;
            sum_reg <= sqa_reg + sqb_reg;
            itb_reg <= ita_reg;
        end
    end

    logic [31:0]   rad;
    logic [IW-1:0] itc_vec;
    rfvt_item_t    itc;
    logic [QW-1:0] qp_c;

    rfvt_sqrt_pipe #(.RW(64), .TW(IW)) u_sqrt_rad (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (sum_reg),
        .tag_i  (itb_reg),
        .root_o (rad),
        .tag_o  (itc_vec)
    );

    assign itc  = rfvt_item_t'(itc_vec);
    assign qp_c = QW'(itc.q) + (QW'(1) << F);

    logic [NWD-1:0]   ux_q, uy_q, mu_q;
    logic [IW+31:0]   td_vec;
    rfvt_item_t       itd;
    logic [QW-1:0]    qp_d;

    rfvt_div_pipe #(.NW(NWD), .DW(32), .TW(IW + 32)) u_div_ux (
        .aclk  (aclk),
        .en    (en),
        .num_i ({itc.p0[31:0], {F{1'b0}}}),
        .den_i (rad),
        .tag_i ({itc_vec, rad}),
        .quo_o (ux_q),
        .tag_o (td_vec)
    );

    rfvt_div_pipe #(.NW(NWD), .DW(32), .TW(1)) u_div_uy (
        .aclk  (aclk),
        .en    (en),
        .num_i ({itc.p1[31:0], {F{1'b0}}}),
        .den_i (rad),
        .tag_i (1'b0),
        .quo_o (uy_q),
        .tag_o ()
    );

    // mu = q / (1 + q)
    rfvt_div_pipe #(.NW(NWD), .DW(32), .TW(1)) u_div_mu (
        .aclk  (aclk),
        .en    (en),
        .num_i ({8'd0, itc.q, {F{1'b0}}}),
        .den_i (32'(qp_c)),
        .tag_i (1'b0),
        .quo_o (mu_q),
        .tag_o ()
    );

    assign itd  = rfvt_item_t'(td_vec[IW+31:32]);
    assign qp_d = QW'(itd.q) + (QW'(1) << F);

    logic [PW-1:0]  prod2_reg;
    logic [T2W-1:0] t2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod2_reg <= PW'(qp_d) * PW'(td_vec[31:0]);
            t2_reg    <= {ux_q[F:0], uy_q[F:0], mu_q[F-1:0], td_vec[IW+31:32]};
        end
    end

    logic [DW2-1:0] dk;
    logic [T2W-1:0] t2e, t2f;
    logic [NWV-1:0] vkep;

    rfvt_sqrt_pipe #(.RW(RW2), .TW(T2W)) u_sqrt_d (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (RW2'(prod2_reg)),
        .tag_i  (t2_reg),
        .root_o (dk),
        .tag_o  (t2e)
    );

    rfvt_div_pipe #(.NW(NWV), .DW(DW2), .TW(T2W)) u_div_vkep (
        .aclk  (aclk),
        .en    (en),
        .num_i ({1'b1, {(2 * F){1'b0}}}),
        .den_i (dk),
        .tag_i (t2e),
        .quo_o (vkep),
        .tag_o (t2f)
    );

    logic [F:0]     uxf, uyf;
    logic [63:0]    vk64;
    logic [PLW-1:0] pxl_reg, pxh_reg, pyl_reg, pyh_reg;
    logic [T3W-1:0] t3p_reg, t3q_reg;

    assign uxf  = t2f[T2W-1 -: F+1];
    assign uyf  = t2f[T2W-F-2 -: F+1];
    assign vk64 = 64'(vkep);

    // vkep split into 32-bit halves for the partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            pxl_reg <= PLW'(vk64[31:0]) * PLW'(uxf);
            pxh_reg <= PLW'(vk64[63:32]) * PLW'(uxf);
            pyl_reg <= PLW'(vk64[31:0]) * PLW'(uyf);
            pyh_reg <= PLW'(vk64[63:32]) * PLW'(uyf);
            t3p_reg <= t2f[T3W-1:0];
        end
    end

    logic [PRW-1:0] prodx, prody;
    logic [33:0]    mx_reg, my_reg;

    assign prodx = (PRW'(pxh_reg) << 32) + PRW'(pxl_reg);
    assign prody = (PRW'(pyh_reg) << 32) + PRW'(pyl_reg);

    // anything past 2^33 saturates anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg  <= (|prodx[PRW-1:F+33]) ? (34'd1 << 33) : {1'b0, prodx[F+32:F]};
            my_reg  <= (|prody[PRW-1:F+33]) ? (34'd1 << 33) : {1'b0, prody[F+32:F]};
            t3q_reg <= t3p_reg;
        end
    end

    rfvt_item_t         itq;
    logic signed [35:0] mu36, mx36, my36, a36, b36;
    logic [32:0]        sa, sb;
    logic [31:0]        res_vx, res_vy;
    status_t            res_st;

    assign itq  = rfvt_item_t'(t3q_reg[IW-1:0]);
    assign mu36 = $signed({{(36 - F){1'b0}}, t3q_reg[T3W-1:IW]});
    assign mx36 = $signed({2'b00, mx_reg});
    assign my36 = $signed({2'b00, my_reg});

    always_comb begin
        a36 = 36'(itq.p0);
        b36 = 36'(itq.p1) - mu36;
        if (itq.kind == K_KEP) begin
            a36 = itq.sy ? mx36 : -mx36;
            b36 = (itq.sx ? -my36 : my36) - mu36;
        end
    end

    assign sa = sat32(a36);
    assign sb = sat32(b36);

    always_comb begin
        res_vx = '0;
        res_vy = '0;
        res_st = ST_OK;
        unique case (itq.kind) inside
            K_ROT, K_KEP: begin
                res_vx = sa[31:0];
                res_vy = sb[31:0];
                res_st = (sa[32] || sb[32]) ? ST_SAT : ST_OK;
            end
            K_PASS: begin
                res_vx = itq.p0[31:0];
                res_vy = itq.p1[31:0];
            end
            K_ZERO: begin
                res_st = ST_ZERO_RAD;
            end
            default: begin
                res_st = ST_BAD_ACTION;
            end
        endcase
    end

    logic        out_v_reg;
    logic [31:0] out_vx_reg, out_vy_reg;
    status_t     out_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_vx_reg <= res_vx;
            out_vy_reg <= res_vy;
            out_st_reg <= res_st;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_vy_reg, out_vx_reg};
    assign m_tuser  = out_st_reg;

`ifndef SYNTHESIS
    a_zero_rad_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_st_reg == ST_ZERO_RAD |-> out_vx_reg == '0 && out_vy_reg == '0)
        else $error("zero radius result carries nonzero velocity");

    a_bad_action_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_st_reg == ST_BAD_ACTION |-> out_vx_reg == '0 && out_vy_reg == '0)
        else $error("unknown action result carries nonzero velocity");

    a_sat_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_st_reg == ST_SAT |->
            out_vx_reg == S32_MAX || out_vx_reg == S32_MIN ||
            out_vy_reg == S32_MAX || out_vy_reg == S32_MIN)
        else $error("saturated status without a clamped component");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

/* design/rotating_frame_velocity_transform_core.sv */
// throughput: one request per cycle; the square roots and dividers are one bit per stage
//   pipelines, and the whole back pipeline halts only while a result waits on m_tready
// reset: synchronous active low, empties the queue and pipeline and sets mass_ratio to 1.0
module rotating_frame_velocity_transform_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // out_vx, out_vy
    output logic [1:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data
);
    import rfvt_pkg::*;

    logic       item_valid;
    logic       item_ready;
    rfvt_item_t item;

    rfvt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    rfvt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* sim/tb_rotating_frame_velocity_transform_core.sv */
`timescale 1ns / 1ps

module tb_rotating_frame_velocity_transform_core;
    import rfvt_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM = 1830;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam longint CLAMP40 = 64'sd1 << 40;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        status_t     st;
    } velocity_t;

    typedef struct packed {
        action_t     act;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        fixed;
        velocity_t   res;
    } dir_row_t;

    localparam int NDIR = 18;
    // mu is 0.5 (32768) at the reset mass ratio
    dir_row_t dir_tab [NDIR] = '{
        '{ACT_BAD, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, ST_BAD_ACTION}},
        '{ACT_BAD, SMAX, SMIN, SMAX, SMIN, 1'b1, '{32'd0, 32'd0, ST_BAD_ACTION}},
        '{ACT_KEP, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, ST_ZERO_RAD}},
        '{ACT_KEP, 32'd0, 32'd0, SMAX, SMIN, 1'b1, '{32'd0, 32'd0, ST_ZERO_RAD}},
        '{ACT_PASS, SMAX, SMAX, SMAX, SMIN, 1'b1, '{SMAX, SMIN, ST_OK}},
        '{ACT_PASS, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, ST_OK}},
        '{ACT_ROT, 32'd0, SMIN, SMAX, 32'd0, 1'b1, '{SMAX, -32'sd32768, ST_SAT}},
        '{ACT_ROT, 32'd0, 32'd1, SMIN, 32'd0, 1'b1, '{SMIN, -32'sd32768, ST_SAT}},
        '{ACT_ROT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, -32'sd32768, ST_OK}},
        '{ACT_ROT, 32'd0, 32'd0, 32'd0, SMIN, 1'b1, '{32'd0, SMIN, ST_SAT}},
        '{ACT_KEP, ONE, 32'd0, 32'd0, 32'd0, 1'b0, '0},
        '{ACT_KEP, 32'd0, ONE, 32'd0, 32'd0, 1'b0, '0},
        '{ACT_KEP, -ONE, -ONE, 32'd5, 32'd7, 1'b0, '0},
        '{ACT_KEP, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, '0},
        '{ACT_KEP, SMIN, SMIN, 32'd0, 32'd0, 1'b0, '0},
        '{ACT_KEP, SMAX, SMAX, 32'd0, 32'd0, 1'b0, '0},
        '{ACT_ROT, SMAX, 32'd0, 32'd0, SMAX, 1'b0, '0},
        '{ACT_ROT, 32'h0003_8000, -32'sh0001_2000, 32'h0000_4000, 32'hFFF0_0000, 1'b0, '0}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [23:0]  cfg_data;

    logic [23:0] mass_ratio_q;
    velocity_t   pending_vel [$];
    int          errors = 0;
    int          cycles = 0;
    int          snd_idle;
    int          rcv_idle;
    int          rcv_hold;

    rotating_frame_velocity_transform_core #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(input longint v, inout logic hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return SMAX;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return SMIN;
        end
        return v[31:0];
    endfunction

    // floor(vkep*u / 2^F), pinned at 2^40 once it can no longer fit
    function automatic longint kep_mag(input longint unsigned vkep, input longint unsigned u);
        logic [127:0] p;
        longint unsigned m;
        p = 128'(vkep) * 128'(u);
        if (p[127:64] != 0) return CLAMP40;
        m = p[79:16];
        if (m > longint'(CLAMP40)) return CLAMP40;
        return longint'(m);
    endfunction

    function automatic velocity_t frame_velocity(input action_t act,
                                                 input logic signed [31:0] xi,
                                                 input logic signed [31:0] yi,
                                                 input logic signed [31:0] vxi,
                                                 input logic signed [31:0] vyi);
        velocity_t r;
        longint x, y, vx, vy, mu, mx, my;
        longint unsigned qp, ax, ay, rad, d, vkep, ux, uy;
        logic hit;
        x = xi;
        y = yi;
        vx = vxi;
        vy = vyi;
        qp = 64'(mass_ratio_q) + 64'd65536;
        mu = longint'((64'(mass_ratio_q) << FRAC) / qp);
        hit = 1'b0;
        r = '{32'd0, 32'd0, ST_OK};
        case (act)
            ACT_ROT: begin
                r.vx = clamp32(vx - y, hit);
                r.vy = clamp32(vy + x - mu, hit);
            end
            ACT_KEP: begin
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                rad = int_sqrt(ax * ax + ay * ay);
                if (rad == 0) begin
                    r.st = ST_ZERO_RAD;
                end else begin
                    d = int_sqrt(qp * rad);
                    vkep = (64'd1 << (2 * FRAC)) / d;
                    ux = (ay << FRAC) / rad;
                    uy = (ax << FRAC) / rad;
                    mx = kep_mag(vkep, ux);
                    my = kep_mag(vkep, uy);
                    r.vx = clamp32((y < 0) ? mx : -mx, hit);
                    r.vy = clamp32(((x < 0) ? -my : my) - mu, hit);
                end
            end
            ACT_PASS: begin
                r.vx = vxi;
                r.vy = vyi;
            end
            default: r.st = ST_BAD_ACTION;
        endcase
        if (r.st == ST_OK && hit) r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // returns after the request is taken; the valid stays high for the caller
    task automatic send_request(input action_t act, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] vx, input logic [31:0] vy,
                                input logic fixed, input velocity_t fixed_res);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {vy, vx, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_vel.push_back(fixed ? fixed_res : frame_velocity(act, x, y, vx, vy));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_vel.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_mass_ratio(input logic [23:0] q);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mass_ratio_q = q;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom_range(1) ? SMAX : SMIN;
            2, 3: return 32'($signed($urandom_range(2 * 4096)) - 4096);
            4, 5, 6: return 32'($signed($urandom_range(2 * (1 << 20))) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(input int n);
        action_t act;
        for (int i = 0; i < n; i++) begin
            act = action_t'($urandom_range(9) < 4 ? ACT_KEP : $urandom_range(3));
            send_request(act, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                         1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rcv_hold > 0) begin
            rcv_hold = rcv_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        velocity_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_vel.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'(m_tuser));
            end else begin
                want = pending_vel.pop_front();
                if (m_tdata[31:0] !== want.vx) report_mismatch("out_vx", m_tdata[31:0], want.vx);
                if (m_tdata[63:32] !== want.vy) report_mismatch("out_vy", m_tdata[63:32], want.vy);
                if (m_tuser !== want.st) report_mismatch("status", 32'(m_tuser), 32'(want.st));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        snd_idle  = 25;
        rcv_idle  = 71;
        rcv_hold  = 0;
        mass_ratio_q = MASS_RATIO_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) begin
            send_request(dir_tab[i].act, dir_tab[i].x, dir_tab[i].y, dir_tab[i].vx,
                         dir_tab[i].vy, dir_tab[i].fixed, dir_tab[i].res);
        end

        // q at both ends of its range, then a random one
        write_mass_ratio(24'd0);
        random_burst(NUM_RANDOM / 6);
        write_mass_ratio(24'hFF_FFFF);
        random_burst(NUM_RANDOM / 6);

        snd_idle = 71;
        rcv_idle = 25;
        write_mass_ratio(24'($urandom));
        random_burst(NUM_RANDOM / 6);
        // sender stops until every pending result is back
        drain_results();
        random_burst(NUM_RANDOM / 6);

        snd_idle = 0;
        rcv_idle = 0;
        write_mass_ratio(MASS_RATIO_RESET);
        // long back-pressure while requests keep coming, so the input stalls
        rcv_hold = 600;
        random_burst(NUM_RANDOM / 6);
        write_mass_ratio(24'($urandom_range(24'h03_0000)));
        random_burst(NUM_RANDOM - 5 * (NUM_RANDOM / 6));

        s_tvalid <= 1'b0;
        wait (pending_vel.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
